[rtl/core/fbpa_pkg.sv]
// Package for the fixed block pool allocator.
// Holds pool sizing constants, status and action codes, the controller state
// type and the command and status structs shared by the controller and datapath.
package fbpa_pkg;

	localparam int MAX_BLOCKS = 256;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int CNT_W      = IDX_W + 1;
	localparam int BYTES_W    = 13;
	localparam int REPORT_W   = 21;
	localparam int PROD_W     = CNT_W + BYTES_W;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 13;

	// Marks "no block" in the free list head and the high-water mark.
	localparam logic [CNT_W-1:0] NO_BLOCK = CNT_W'(MAX_BLOCKS);

	localparam logic [CNT_W-1:0]   BLOCK_COUNT_RST = CNT_W'(256);
	localparam logic [BYTES_W-1:0] BLOCK_BYTES_RST = BYTES_W'(64);

	localparam logic [REPORT_W-1:0] REPORT_MAX = '1;

	// Request actions.
	localparam logic ACT_ALLOC = 1'b0;
	localparam logic ACT_FREE  = 1'b1;

	// Result status codes.
	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_FULL     = 2'd1;
	localparam logic [1:0] STATUS_BAD_FREE = 2'd2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_BLOCK_BYTES = CFG_IDX_W'(1);

	typedef enum logic {
		FSM_IDLE,
		FSM_UPDATE
	} fsm_state_t;

	typedef struct packed {
		logic capture;
		logic update;
	} dp_cmd_t;

	typedef struct packed {
		logic slot_free;
	} dp_stat_t;

endpackage

[rtl/core/fbpa_intf.sv]
// Handshake interfaces of the fixed block pool allocator: request, result and
// configuration write channels. Depends on fbpa_pkg.
interface fbpa_req_if;
	logic                     valid;
	logic                     ready;
	logic                     action;
	logic [fbpa_pkg::IDX_W-1:0] block_index;

	modport source (output valid, action, block_index, input ready);
	modport sink   (input valid, action, block_index, output ready);
endinterface

interface fbpa_rsp_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    status;
	logic [fbpa_pkg::IDX_W-1:0]    granted_index;
	logic [fbpa_pkg::CNT_W-1:0]    blocks_in_use;
	logic [fbpa_pkg::REPORT_W-1:0] occupied_bytes;
	logic [fbpa_pkg::REPORT_W-1:0] remaining_bytes;

	modport source (output valid, status, granted_index, blocks_in_use, occupied_bytes,
		remaining_bytes, input ready);
	modport sink   (input valid, status, granted_index, blocks_in_use, occupied_bytes,
		remaining_bytes, output ready);
endinterface

interface fbpa_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [fbpa_pkg::CFG_IDX_W-1:0]  index;
	logic [fbpa_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/fbpa_ctrl.sv]
// Controller state machine of the fixed block pool allocator.
// Depends on fbpa_pkg; drives the datapath through dp_cmd_t.
module fbpa_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  fbpa_pkg::dp_stat_t stat,
	output fbpa_pkg::dp_cmd_t  cmd
);
	import fbpa_pkg::*;

	fsm_state_t state_q;
	fsm_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			FSM_IDLE: begin
				if (req_valid && stat.slot_free) begin
					state_d = FSM_UPDATE;
				end
			end
			FSM_UPDATE: begin
				state_d = FSM_IDLE;
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready   = 1'b0;
		cmd.capture = 1'b0;
		cmd.update  = 1'b0;
		case (state_q)
			FSM_IDLE: begin
				req_ready   = stat.slot_free;
				cmd.capture = req_valid && stat.slot_free;
			end
			FSM_UPDATE: begin
				cmd.update = 1'b1;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

endmodule

[rtl/core/fbpa_datapath.sv]
// Datapath of the fixed block pool allocator: link memory, allocated bits,
// list pointers, configuration registers, report stage and result register.
// Depends on fbpa_pkg; commanded by fbpa_ctrl.
module fbpa_datapath (
	input  logic                            clk,
	input  logic                            arst_n,
	input  fbpa_pkg::dp_cmd_t               cmd,
	output fbpa_pkg::dp_stat_t              stat,
	input  logic                            req_action,
	input  logic [fbpa_pkg::IDX_W-1:0]      req_block_index,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [fbpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data,
	output logic                            rsp_valid,
	input  logic                            rsp_ready,
	output logic [1:0]                      rsp_status,
	output logic [fbpa_pkg::IDX_W-1:0]      rsp_granted_index,
	output logic [fbpa_pkg::CNT_W-1:0]      rsp_blocks_in_use,
	output logic [fbpa_pkg::REPORT_W-1:0]   rsp_occupied_bytes,
	output logic [fbpa_pkg::REPORT_W-1:0]   rsp_remaining_bytes
);
	import fbpa_pkg::*;

	function automatic logic [REPORT_W-1:0] sat_report(input logic [PROD_W-1:0] prod);
		logic [REPORT_W-1:0] res;
		if (prod > PROD_W'(REPORT_MAX)) begin
			res = REPORT_MAX;
		end else begin
			res = prod[REPORT_W-1:0];
		end
		return res;
	endfunction

	// Configuration.
	logic [CNT_W-1:0]   count_q;
	logic [BYTES_W-1:0] block_bytes_q;
	logic               cfg_fire;
	logic               reinit;
	logic [CNT_W-1:0]   cfg_count_raw;
	logic [CNT_W-1:0]   cfg_count_eff;

	// Pool state.
	logic [CNT_W-1:0]      free_head_q;
	logic [CNT_W-1:0]      high_water_q;
	logic [CNT_W-1:0]      in_use_q;
	logic [CNT_W-1:0]      link_mem [MAX_BLOCKS];
	logic [CNT_W-1:0]      link_rd_q;
	logic                  flag_mem [MAX_BLOCKS];
	logic                  flag_rd_q;
	logic                  flag_we;
	logic                  flag_wr_val;
	logic [IDX_W-1:0]      flag_wr_addr;
	logic                  blk_owned;

	// Captured request.
	logic             req_action_q;
	logic [IDX_W-1:0] req_index_q;

	// Update logic.
	logic [CNT_W-1:0] head_d;
	logic [CNT_W-1:0] hw_d;
	logic [CNT_W-1:0] use_d;
	logic [CNT_W-1:0] head_inc;
	logic [CNT_W-1:0] free_blk;
	logic [1:0]       status_d;
	logic [IDX_W-1:0] granted_d;
	logic             set_flag;
	logic             clr_flag;
	logic             link_we;

	// Report stage and result register.
	logic             rep_valid_s1;
	logic [1:0]       rep_status_s1;
	logic [IDX_W-1:0] rep_granted_s1;
	logic [CNT_W-1:0] rep_in_use_s1;
	logic             out_free;
	logic             rep_move;
	logic [CNT_W-1:0] rep_free_cnt;
	logic [PROD_W-1:0] occ_prod;
	logic [PROD_W-1:0] rem_prod;

	assign cfg_ready     = 1'b1;
	assign cfg_fire      = cfg_valid && cfg_ready;
	assign reinit        = cfg_fire && (cfg_index == REG_BLOCK_COUNT);
	assign cfg_count_raw = cfg_data[CNT_W-1:0];

	always_comb begin
		if (cfg_count_raw == '0) begin
			cfg_count_eff = CNT_W'(1);
		end else if (cfg_count_raw > CNT_W'(MAX_BLOCKS)) begin
			cfg_count_eff = CNT_W'(MAX_BLOCKS);
		end else begin
			cfg_count_eff = cfg_count_raw;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q       <= BLOCK_COUNT_RST;
			block_bytes_q <= BLOCK_BYTES_RST;
		end else if (cfg_fire) begin
			if (cfg_index == REG_BLOCK_COUNT) begin
				count_q <= cfg_count_eff;
			end else if (cfg_index == REG_BLOCK_BYTES) begin
				block_bytes_q <= cfg_data[BYTES_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			req_action_q <= req_action;
			req_index_q  <= req_block_index;
		end
	end

	// The link word of the current head is read while the request is taken.
	always_ff @(posedge clk) begin
		if (cmd.update && link_we) begin
			link_mem[req_index_q] <= free_head_q;
		end
		if (cmd.capture) begin
			link_rd_q <= link_mem[free_head_q[IDX_W-1:0]];
		end
	end

	// Allocated bits, read for the named block while the request is taken. Only
	// blocks below the high-water mark can have been handed out since the pool
	// was last emptied, so the stored bit of any other block is stale.
	assign flag_we      = set_flag || clr_flag;
	assign flag_wr_val  = set_flag;
	assign flag_wr_addr = set_flag ? free_head_q[IDX_W-1:0] : req_index_q;

	always_ff @(posedge clk) begin
		if (cmd.update && flag_we) begin
			flag_mem[flag_wr_addr] <= flag_wr_val;
		end
		if (cmd.capture) begin
			flag_rd_q <= flag_mem[req_block_index];
		end
	end

	assign head_inc  = free_head_q + CNT_W'(1);
	assign free_blk  = {1'b0, req_index_q};
	assign blk_owned = (free_blk < high_water_q) && flag_rd_q;

	always_comb begin
		head_d    = free_head_q;
		hw_d      = high_water_q;
		use_d     = in_use_q;
		status_d  = STATUS_OK;
		granted_d = '0;
		set_flag  = 1'b0;
		clr_flag  = 1'b0;
		link_we   = 1'b0;
		if (req_action_q == ACT_ALLOC) begin
			if (free_head_q >= count_q) begin
				status_d = STATUS_FULL;
			end else begin
				set_flag  = 1'b1;
				use_d     = in_use_q + CNT_W'(1);
				granted_d = free_head_q[IDX_W-1:0];
				if (free_head_q == high_water_q) begin
					// Head is the first never-used block: advance the mark.
					if (head_inc == count_q) begin
						head_d = NO_BLOCK;
						hw_d   = NO_BLOCK;
					end else begin
						head_d = head_inc;
						hw_d   = head_inc;
					end
				end else begin
					head_d = link_rd_q;
				end
			end
		end else begin
			if ((free_blk >= count_q) || !blk_owned) begin
				status_d = STATUS_BAD_FREE;
			end else begin
				link_we  = 1'b1;
				clr_flag = 1'b1;
				head_d   = free_blk;
				if (in_use_q != '0) begin
					use_d = in_use_q - CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q  <= '0;
			high_water_q <= '0;
			in_use_q     <= '0;
		end else if (reinit) begin
			free_head_q  <= '0;
			high_water_q <= '0;
			in_use_q     <= '0;
		end else if (cmd.update) begin
			free_head_q  <= head_d;
			high_water_q <= hw_d;
			in_use_q     <= use_d;
		end
	end

	// Report stage: holds the outcome until the result register has room.
	assign out_free       = !rsp_valid || rsp_ready;
	assign rep_move       = rep_valid_s1 && out_free;
	assign stat.slot_free = !rep_valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rep_valid_s1 <= 1'b0;
		end else if (cmd.update) begin
			rep_valid_s1 <= 1'b1;
		end else if (rep_move) begin
			rep_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.update) begin
			rep_status_s1  <= status_d;
			rep_granted_s1 <= granted_d;
			rep_in_use_s1  <= use_d;
		end
	end

	assign rep_free_cnt = (count_q >= rep_in_use_s1) ? (count_q - rep_in_use_s1) : '0;
	assign occ_prod     = PROD_W'(rep_in_use_s1) * PROD_W'(block_bytes_q);
	assign rem_prod     = PROD_W'(rep_free_cnt) * PROD_W'(block_bytes_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid <= 1'b0;
		end else if (rep_move) begin
			rsp_valid <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rep_move) begin
			rsp_status          <= rep_status_s1;
			rsp_granted_index   <= rep_granted_s1;
			rsp_blocks_in_use   <= rep_in_use_s1;
			rsp_occupied_bytes  <= sat_report(occ_prod);
			rsp_remaining_bytes <= sat_report(rem_prod);
		end
	end

endmodule

[rtl/core/fixed_block_pool_allocator.sv]
// Top level of the fixed block pool allocator.
// Depends on fbpa_pkg, the channel interfaces, fbpa_ctrl and fbpa_datapath.
//
// This block hands out and takes back equal-size blocks of a pool of up to
// 256 blocks. Each request transaction (action 0 allocate, action 1 free with
// block_index) produces exactly one result transaction carrying a status, the
// granted block index, the blocks in use and the occupied and remaining byte
// counts. The free list is built lazily: an allocate takes the list head, and
// when the head equals the high-water mark the next never-used block is taken
// instead, so no initialization pass is needed after reset or after a write
// of block_count, which empties the pool at once. A per-block allocated bit
// rejects a free of a block that is out of range or not allocated (status 2);
// an allocate on a full pool answers status 1. The allocated bits live in a
// small memory, and a bit counts only for blocks below the high-water mark, as
// no other block can have been handed out since the pool was emptied. When a
// request is taken, the successor link of the list head and the allocated bit
// of the named block are read from the synchronous memories; the update state
// then updates the list and the allocated bit and writes the link of a freed
// block. No new request is taken in the update state, nor while the report
// stage is full and cannot move on; one finished result may wait in the
// output register while the next request is being worked on, and the byte
// counts are formed in a report stage between the update and the output
// register. Configuration writes are always taken and must only be issued
// while no request is outstanding.
module fixed_block_pool_allocator (
	input  logic       clk,
	input  logic       arst_n,
	fbpa_req_if.sink   req,
	fbpa_rsp_if.source rsp,
	fbpa_cfg_if.sink   cfg
);
	import fbpa_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The controller paces requests; it only sees whether a result slot is free.
	fbpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	// The datapath owns all pool state, configuration and the result register.
	fbpa_datapath u_datapath (
		.clk                 (clk),
		.arst_n              (arst_n),
		.cmd                 (cmd),
		.stat                (stat),
		.req_action          (req.action),
		.req_block_index     (req.block_index),
		.cfg_valid           (cfg.valid),
		.cfg_ready           (cfg.ready),
		.cfg_index           (cfg.index),
		.cfg_data            (cfg.data),
		.rsp_valid           (rsp.valid),
		.rsp_ready           (rsp.ready),
		.rsp_status          (rsp.status),
		.rsp_granted_index   (rsp.granted_index),
		.rsp_blocks_in_use   (rsp.blocks_in_use),
		.rsp_occupied_bytes  (rsp.occupied_bytes),
		.rsp_remaining_bytes (rsp.remaining_bytes)
	);

endmodule

[rtl/core/fbpa_checker.sv]
// Port-level checks for the fixed block pool allocator, bound to the top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator.
module fbpa_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic                            rsp_valid,
	input logic                            rsp_ready,
	input logic [1:0]                      rsp_status,
	input logic [fbpa_pkg::IDX_W-1:0]      rsp_granted_index,
	input logic [fbpa_pkg::CNT_W-1:0]      rsp_blocks_in_use,
	input logic [fbpa_pkg::REPORT_W-1:0]   rsp_remaining_bytes
);
	import fbpa_pkg::*;

	// A waiting status, index and use count must not change under a stall.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_status) && $stable(rsp_granted_index)
			&& $stable(rsp_blocks_in_use))
		else $error("result changed while stalled");

	// Only a successful allocate names a block.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status != STATUS_OK) |-> rsp_granted_index == '0)
		else $error("failed request carries a granted index");

	// A full pool has every block in use, so nothing remains.
	assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (rsp_status == STATUS_FULL) |-> rsp_remaining_bytes == '0)
		else $error("pool full reported with bytes remaining");

	// The update state after each taken request keeps the next one out.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("request taken in consecutive cycles");

endmodule

bind fixed_block_pool_allocator fbpa_checker u_fbpa_checker (
	.clk                 (clk),
	.arst_n              (arst_n),
	.req_valid           (req.valid),
	.req_ready           (req.ready),
	.rsp_valid           (rsp.valid),
	.rsp_ready           (rsp.ready),
	.rsp_status          (rsp.status),
	.rsp_granted_index   (rsp.granted_index),
	.rsp_blocks_in_use   (rsp.blocks_in_use),
	.rsp_remaining_bytes (rsp.remaining_bytes)
);

[tb/pool_usage_checker.sv]
// Checker for the fixed block pool allocator: predicts every result from the request
// and configuration transactions and compares it with what the result channel delivers.
// Depends on fbpa_pkg and the channel interfaces of fbpa_intf.sv.
module pool_usage_checker (
	input  logic        clk,
	input  logic        arst_n,
	fbpa_req_if         req,
	fbpa_rsp_if         rsp,
	fbpa_cfg_if         cfg,
	output int unsigned mismatches,
	output int unsigned expected_left
);
	import fbpa_pkg::*;

	typedef struct packed {
		logic [1:0]          status;
		logic [IDX_W-1:0]    granted;
		logic [CNT_W-1:0]    in_use;
		logic [REPORT_W-1:0] occupied;
		logic [REPORT_W-1:0] remaining;
	} pool_report_t;

	// Shadow of the pool state and of the two registers.
	logic [CNT_W-1:0]   link_mem [MAX_BLOCKS];
	logic               owned [MAX_BLOCKS];
	logic [CNT_W-1:0]   head;
	logic [CNT_W-1:0]   water;
	logic [CNT_W-1:0]   in_use;
	logic [CNT_W-1:0]   count_reg;
	logic [BYTES_W-1:0] bytes_reg;

	pool_report_t expected_reports[$];

	function automatic void clear_pool();
		for (int i = 0; i < MAX_BLOCKS; i++) begin
			link_mem[i] = '0;
			owned[i] = 1'b0;
		end
		head = '0;
		water = '0;
		in_use = '0;
	endfunction

	function automatic logic [REPORT_W-1:0] byte_report(logic [CNT_W-1:0] blocks);
		longint unsigned product;
		product = longint'(blocks) * longint'(bytes_reg);
		return (product > REPORT_MAX) ? REPORT_MAX : product[REPORT_W-1:0];
	endfunction

	function automatic pool_report_t predict_report(logic act, logic [IDX_W-1:0] idx);
		pool_report_t report;
		logic [CNT_W-1:0] eff;
		logic [CNT_W-1:0] blk;
		report = '0;
		if (count_reg == 0)
			eff = CNT_W'(1);
		else if (count_reg > MAX_BLOCKS)
			eff = CNT_W'(MAX_BLOCKS);
		else
			eff = count_reg;
		if (act == ACT_ALLOC) begin
			blk = head;
			if (blk >= eff) begin
				report.status = STATUS_FULL;
			end else begin
				// A head at the high-water mark means the list is exhausted and the
				// next never-used block follows.
				if (blk == water) begin
					if (blk + 1 == eff) begin
						head = NO_BLOCK;
						water = NO_BLOCK;
					end else begin
						head = blk + 1'b1;
						water = blk + 1'b1;
					end
				end else begin
					head = link_mem[blk[IDX_W-1:0]];
				end
				owned[blk[IDX_W-1:0]] = 1'b1;
				in_use = in_use + 1'b1;
				report.granted = blk[IDX_W-1:0];
			end
		end else begin
			blk = {1'b0, idx};
			if (blk >= eff || !owned[idx]) begin
				report.status = STATUS_BAD_FREE;
			end else begin
				link_mem[idx] = head;
				head = blk;
				owned[idx] = 1'b0;
				if (in_use != 0)
					in_use = in_use - 1'b1;
			end
		end
		report.in_use = in_use;
		report.occupied = byte_report(in_use);
		report.remaining = byte_report((eff >= in_use) ? eff - in_use : '0);
		return report;
	endfunction

	task automatic check_field(string name, logic [REPORT_W-1:0] want, logic [REPORT_W-1:0] got);
		if (got !== want) begin
			$error("wrong %s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		pool_report_t want;
		if (!arst_n) begin
			count_reg = BLOCK_COUNT_RST;
			bytes_reg = BLOCK_BYTES_RST;
			clear_pool();
			expected_reports.delete();
			mismatches = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_BLOCK_COUNT) begin
					count_reg = cfg.data[CNT_W-1:0];
					clear_pool();
				end else if (cfg.index == REG_BLOCK_BYTES) begin
					bytes_reg = cfg.data[BYTES_W-1:0];
				end
			end
			if (req.valid && req.ready)
				expected_reports.push_back(predict_report(req.action, req.block_index));
			if (rsp.valid && rsp.ready) begin
				if (expected_reports.size() == 0) begin
					$error("result transaction with no request outstanding");
					mismatches++;
				end else begin
					want = expected_reports.pop_front();
					check_field("status", want.status, rsp.status);
					check_field("granted_index", want.granted, rsp.granted_index);
					check_field("blocks_in_use", want.in_use, rsp.blocks_in_use);
					check_field("occupied_bytes", want.occupied, rsp.occupied_bytes);
					check_field("remaining_bytes", want.remaining, rsp.remaining_bytes);
				end
			end
		end
		expected_left = expected_reports.size();
	end

endmodule

[tb/testbench.sv]
// Top of the fixed block pool allocator testbench: clock, reset, request and
// configuration stimulus, result back-pressure and the final verdict.
// Depends on fbpa_pkg, fbpa_intf.sv, the allocator RTL and pool_usage_checker.
module testbench;
	import fbpa_pkg::*;

	logic clk = 1'b0;
	logic arst_n;

	fbpa_req_if req_ch();
	fbpa_rsp_if rsp_ch();
	fbpa_cfg_if cfg_ch();

	int unsigned mismatches;
	int unsigned expected_left;

	// When calm is set neither the request side nor the result side idles.
	bit          calm;
	int unsigned stall_left;

	// Actions of the request transactions whose result has not come back yet,
	// oldest first. The result channel answers strictly in order.
	logic             in_flight[$];
	// Blocks that were granted and not yet handed back by this testbench. Most
	// frees pick from here so that they are well formed.
	logic [IDX_W-1:0] held[$];

	int unsigned pool_size;
	int unsigned settings_used = 1;
	int unsigned requests_sent = 0;
	int unsigned grants = 0;
	int unsigned full_answers = 0;
	int unsigned rejected_frees = 0;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	fixed_block_pool_allocator i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	pool_usage_checker i_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.req           (req_ch),
		.rsp           (rsp_ch),
		.cfg           (cfg_ch),
		.mismatches    (mismatches),
		.expected_left (expected_left)
	);

	// Result back-pressure. Stalls come in bursts that start at random, so that
	// they land on both the taking and the update of a request and on a result that
	// waits in the output register while the next request is in work.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_ch.ready <= 1'b0;
			stall_left <= 0;
		end else if (calm) begin
			rsp_ch.ready <= 1'b1;
		end else if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			rsp_ch.ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 12);
			rsp_ch.ready <= 1'b0;
		end else begin
			rsp_ch.ready <= 1'b1;
		end
	end

	// Retire each result transaction against the action that caused it. Granted
	// blocks become candidates for later frees.
	always @(posedge clk) begin
		logic act;
		if (arst_n && rsp_ch.valid && rsp_ch.ready && in_flight.size() != 0) begin
			act = in_flight.pop_front();
			if (rsp_ch.status == STATUS_FULL)
				full_answers++;
			else if (rsp_ch.status == STATUS_BAD_FREE)
				rejected_frees++;
			else if (act == ACT_ALLOC) begin
				grants++;
				held.push_back(rsp_ch.granted_index);
			end
		end
	end

	// Issue one request transaction, possibly after a gap, and return at the
	// clock edge that accepts it. Valid stays high so that a following request
	// goes out back to back.
	task automatic send_request(input logic act, input logic [IDX_W-1:0] idx);
		if (!calm && $urandom_range(0, 3) == 0) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.action <= act;
		req_ch.block_index <= idx;
		do @(posedge clk); while (!req_ch.ready);
		in_flight.push_back(act);
		requests_sent++;
	endtask

	// Stop requesting and wait until every result has been taken, so that the
	// block is really idle before the registers change.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (in_flight.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Write block_bytes and then block_count. The count write empties the pool,
	// so the list of held blocks is dropped as well.
	task automatic set_pool(input logic [CFG_DATA_W-1:0] count_val,
			input logic [CFG_DATA_W-1:0] bytes_val);
		logic [CNT_W-1:0] masked;
		drain();
		held.delete();
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= REG_BLOCK_BYTES;
		cfg_ch.data <= bytes_val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.index <= REG_BLOCK_COUNT;
		cfg_ch.data <= count_val;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		// Only the low nine bits of the count are kept; zero acts as one block and
		// anything above the pool limit as the full pool.
		masked = count_val[CNT_W-1:0];
		if (masked == 0)
			pool_size = 1;
		else if (masked > MAX_BLOCKS)
			pool_size = MAX_BLOCKS;
		else
			pool_size = masked;
		settings_used++;
	endtask

	initial begin
		int unsigned count_val;
		int unsigned bytes_val;
		int unsigned n_items;
		int unsigned alloc_pct;
		int unsigned k;
		logic [IDX_W-1:0] idx;

		arst_n <= 1'b0;
		req_ch.valid <= 1'b0;
		req_ch.action <= ACT_ALLOC;
		req_ch.block_index <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.index <= REG_BLOCK_COUNT;
		cfg_ch.data <= '0;
		calm = 1'b0;
		pool_size = MAX_BLOCKS;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part, first with the reset settings of 256 blocks of 64 bytes.
		// Three allocates come from the never-used region, two frees build a
		// list, and the next allocates walk that list before the high-water mark
		// takes over again.
		send_request(ACT_ALLOC, IDX_W'($urandom_range(0, 255)));
		send_request(ACT_ALLOC, IDX_W'($urandom_range(0, 255)));
		send_request(ACT_ALLOC, IDX_W'($urandom_range(0, 255)));
		send_request(ACT_FREE, 8'd1);
		send_request(ACT_FREE, 8'd0);
		// A second free of the same block is rejected.
		send_request(ACT_FREE, 8'd1);
		send_request(ACT_ALLOC, 8'd255);
		send_request(ACT_ALLOC, 8'd0);
		send_request(ACT_ALLOC, IDX_W'($urandom_range(0, 255)));
		// Frees of blocks that were never handed out, at the top and middle of the index.
		send_request(ACT_FREE, 8'd255);
		send_request(ACT_FREE, 8'd128);

		// Two blocks with the largest block size: free a block that is not held,
		// fill the pool, hit the full answer, then free one and try one past the end.
		set_pool(13'd2, 13'd8191);
		send_request(ACT_FREE, 8'd0);
		send_request(ACT_ALLOC, IDX_W'($urandom_range(0, 255)));
		send_request(ACT_ALLOC, IDX_W'($urandom_range(0, 255)));
		send_request(ACT_ALLOC, IDX_W'($urandom_range(0, 255)));
		send_request(ACT_FREE, 8'd1);
		send_request(ACT_FREE, 8'd2);
		send_request(ACT_ALLOC, IDX_W'($urandom_range(0, 255)));

		// A count of zero acts as a single block; zero-byte blocks report no bytes.
		set_pool(13'd0, 13'd0);
		send_request(ACT_ALLOC, IDX_W'($urandom_range(0, 255)));
		send_request(ACT_ALLOC, IDX_W'($urandom_range(0, 255)));
		send_request(ACT_FREE, 8'd0);
		send_request(ACT_ALLOC, IDX_W'($urandom_range(0, 255)));

		// An oversized count is clamped to the full pool.
		set_pool(13'h1FFF, 13'd4096);
		send_request(ACT_ALLOC, IDX_W'($urandom_range(0, 255)));
		send_request(ACT_FREE, 8'd255);

		// Random part. Each phase picks a pool setting and then runs a stream of
		// allocates and frees. Most frees return a block that is known to be
		// held; the rest are random indexes, many of them rejected. One long
		// phase is biased toward allocates so that the full 256-block pool runs
		// dry. The last phase runs without any idling.
		for (int p = 0; p < 8; p++) begin
			n_items = 30;
			alloc_pct = 55;
			case (p)
				0: begin
					count_val = 1;
					bytes_val = 1;
				end
				1: begin
					count_val = 2;
					bytes_val = 8191;
				end
				2: begin
					count_val = $urandom_range(3, 16);
					bytes_val = $urandom_range(1, 8191);
				end
				3: begin
					count_val = $urandom_range(1, 256);
					bytes_val = 0;
				end
				4: begin
					count_val = $urandom_range(257, 8191);
					bytes_val = $urandom_range(0, 8191);
				end
				5: begin
					count_val = 256;
					bytes_val = 4096;
					n_items = 300;
					alloc_pct = 97;
				end
				6: begin
					count_val = $urandom_range(1, 40);
					bytes_val = $urandom_range(0, 8191);
				end
				default: begin
					count_val = 8;
					bytes_val = 64;
					n_items = 40;
				end
			endcase
			set_pool(CFG_DATA_W'(count_val), CFG_DATA_W'(bytes_val));
			if (p == 7)
				calm = 1'b1;
			for (int i = 0; i < n_items; i++) begin
				if ($urandom_range(0, 99) < alloc_pct) begin
					send_request(ACT_ALLOC, IDX_W'($urandom_range(0, 255)));
				end else if (held.size() != 0 && $urandom_range(0, 9) < 8) begin
					k = $urandom_range(0, held.size() - 1);
					idx = held[k];
					held.delete(k);
					send_request(ACT_FREE, idx);
				end else if ($urandom_range(0, 1) == 0) begin
					send_request(ACT_FREE, IDX_W'($urandom_range(0, pool_size - 1)));
				end else begin
					send_request(ACT_FREE, IDX_W'($urandom_range(0, 255)));
				end
			end
		end

		drain();
		repeat (8) @(posedge clk);

		$display("Run covered %0d requests under %0d pool settings:",
			requests_sent, settings_used);
		$display("%0d grants, %0d full answers, %0d rejected frees.",
			grants, full_answers, rejected_frees);
		if (expected_left != 0)
			$error("%0d predicted results never arrived", expected_left);
		if (mismatches == 0 && expected_left == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Guard against a hung handshake; the slowest correct run stays far below this.
	initial begin
		#2000000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
